>>> sv/fpfe_pkg.sv
package fpfe_pkg;

	localparam int ADC_W = 10;
	localparam int INDEX_W = 9;
	localparam int ACC_W = 20;
	localparam int BASE_W = 13;
	localparam int DIFF_W = ADC_W + 1;

	localparam logic [ADC_W-1:0] ADC_FULL = 10'd1023;
	localparam logic [BASE_W-1:0] BASE_MAX = 13'd8191;
	localparam logic [INDEX_W-1:0] INDEX_MAX = 9'd511;
	localparam logic signed [ACC_W:0] SAT_HI = 21'sd524287;
	localparam logic signed [ACC_W:0] SAT_LO = -21'sd524288;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_WINDOW_START    = 2'd0,
		REG_WINDOW_END      = 2'd1,
		REG_PEDESTAL_OFFSET = 2'd2,
		REG_PEAK_THRESH     = 2'd3
	} reg_index_t;

	localparam logic [INDEX_W-1:0] WINDOW_START_RST = 9'd0;
	localparam logic [INDEX_W-1:0] WINDOW_END_RST = 9'd511;
	localparam logic [ADC_W-1:0] PEDESTAL_OFFSET_RST = 10'd500;
	localparam logic [ADC_W-1:0] PEAK_THRESH_RST = 10'd50;

	typedef struct packed {
		logic [INDEX_W-1:0] window_start;
		logic [INDEX_W-1:0] window_end;
		logic [ADC_W-1:0]   pedestal_offset;
		logic [ADC_W-1:0]   peak_thresh;
	} cfg_t;

	typedef struct packed {
		logic [ADC_W-1:0]          window_max;
		logic                      window_hit;
		logic signed [ACC_W-1:0]   window_integral;
		logic signed [ACC_W-1:0]   pedestal_integral;
		logic [BASE_W-1:0]         baseline_sum;
		logic [ADC_W-1:0]          peak_value;
		logic [INDEX_W-1:0]        peak_index;
		logic                      clean_pulse;
	} res_t;

endpackage

>>> sv/fpfe_accum.sv
module fpfe_accum #(
	parameter int MAX_SAMPLES = 512,
	parameter int BASELINE_SAMPLES = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [fpfe_pkg::ADC_W-1:0]     sample,
	input  logic                           last,
	input  fpfe_pkg::cfg_t                 cfg,
	output fpfe_pkg::res_t                 res
);
	import fpfe_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam int PROD_W = ADC_W + $clog2(BASELINE_SAMPLES + 1);
	localparam int CL_W = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;

	logic [CNT_W-1:0]        count_q, count_n;
	logic signed [ACC_W-1:0] win_acc_q, win_acc_n;
	logic signed [ACC_W-1:0] ped_acc_q, ped_acc_n;
	logic [ADC_W-1:0]        win_peak_q, win_peak_n;
	logic                    win_seen_q, win_seen_n;
	logic [BASE_W-1:0]       base_acc_q, base_acc_n;
	logic [ADC_W-1:0]        tail_peak_q, tail_peak_n;
	logic [INDEX_W-1:0]      tail_idx_q, tail_idx_n;
	logic                    tail_seen_q, tail_seen_n;

	logic [CMP_W-1:0]        n_ext;
	logic signed [DIFF_W-1:0] diff;
	logic                    in_win;
	logic [BASE_W:0]         base_sum;
	logic [CL_W-1:0]         clean_lhs;
	logic [CL_W-1:0]         clean_rhs;
	logic                    clean;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]  acc,
		input logic signed [DIFF_W-1:0] d
	);
		logic signed [ACC_W:0] s;
		s = $signed({acc[ACC_W-1], acc}) + $signed({{(ACC_W+1-DIFF_W){d[DIFF_W-1]}}, d});
		if (s > SAT_HI) begin
			return SAT_HI[ACC_W-1:0];
		end else if (s < SAT_LO) begin
			return SAT_LO[ACC_W-1:0];
		end
		return s[ACC_W-1:0];
	endfunction

	always_comb begin
		count_n = count_q;
		win_acc_n = win_acc_q;
		ped_acc_n = ped_acc_q;
		win_peak_n = win_peak_q;
		win_seen_n = win_seen_q;
		base_acc_n = base_acc_q;
		tail_peak_n = tail_peak_q;
		tail_idx_n = tail_idx_q;
		tail_seen_n = tail_seen_q;

		n_ext = CMP_W'(count_q);
		diff = $signed({1'b0, sample}) - $signed({1'b0, cfg.pedestal_offset});
		in_win = (n_ext >= CMP_W'(cfg.window_start)) && (n_ext <= CMP_W'(cfg.window_end));
		base_sum = {1'b0, base_acc_q} + (BASE_W+1)'(sample);

		if (count_q < CNT_W'(MAX_SAMPLES)) begin
			if (in_win) begin
				win_acc_n = sat_add(win_acc_q, diff);
				if (!win_seen_q || sample > win_peak_q) begin
					win_peak_n = sample;
				end
				win_seen_n = 1'b1;
			end
			if (n_ext < CMP_W'(cfg.window_start)) begin
				ped_acc_n = sat_add(ped_acc_q, diff);
			end
			if (n_ext < CMP_W'(BASELINE_SAMPLES)) begin
				if (base_sum > (BASE_W+1)'(BASE_MAX)) begin
					base_acc_n = BASE_MAX;
				end else begin
					base_acc_n = base_sum[BASE_W-1:0];
				end
			end else if (!tail_seen_q || sample > tail_peak_q) begin
				tail_peak_n = sample;
				if (n_ext > CMP_W'(INDEX_MAX)) begin
					tail_idx_n = INDEX_MAX;
				end else begin
					tail_idx_n = n_ext[INDEX_W-1:0];
				end
				tail_seen_n = 1'b1;
			end
			count_n = count_q + CNT_W'(1);
		end

		clean_lhs = CL_W'(BASELINE_SAMPLES) * CL_W'(tail_peak_n);
		clean_rhs = CL_W'(BASELINE_SAMPLES) * CL_W'(cfg.peak_thresh) + CL_W'(base_acc_n);
		clean = (count_n > CNT_W'(BASELINE_SAMPLES)) && tail_seen_n &&
			(tail_peak_n != ADC_FULL) && (clean_lhs >= clean_rhs);

		res.window_max = win_seen_n ? win_peak_n : '0;
		res.window_hit = win_seen_n;
		res.window_integral = win_acc_n;
		res.pedestal_integral = ped_acc_n;
		res.baseline_sum = base_acc_n;
		res.peak_value = tail_seen_n ? tail_peak_n : '0;
		res.peak_index = tail_seen_n ? tail_idx_n : '0;
		res.clean_pulse = clean;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			win_acc_q <= '0;
			ped_acc_q <= '0;
			win_peak_q <= '0;
			win_seen_q <= 1'b0;
			base_acc_q <= '0;
			tail_peak_q <= '0;
			tail_idx_q <= '0;
			tail_seen_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				count_q <= '0;
				win_acc_q <= '0;
				ped_acc_q <= '0;
				win_peak_q <= '0;
				win_seen_q <= 1'b0;
				base_acc_q <= '0;
				tail_peak_q <= '0;
				tail_idx_q <= '0;
				tail_seen_q <= 1'b0;
			end else begin
				count_q <= count_n;
				win_acc_q <= win_acc_n;
				ped_acc_q <= ped_acc_n;
				win_peak_q <= win_peak_n;
				win_seen_q <= win_seen_n;
				base_acc_q <= base_acc_n;
				tail_peak_q <= tail_peak_n;
				tail_idx_q <= tail_idx_n;
				tail_seen_q <= tail_seen_n;
			end
		end
	end

endmodule

>>> sv/fadc_pulse_feature_extractor.sv
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   sample, last
// out       source     out_valid/out_stall window_max ... clean_pulse
// apb       slave      psel/penable/pready paddr, pwdata, prdata
//
// One sample is taken every cycle unless in_stall is high; a stepped last sample loads the result.
// Input register and result register form the pipeline; the accumulator result is combinational.
// Reset loads the configuration defaults and clears the per-waveform state and the valid flags.
// A stalled result holds its register; input is stalled only when a last sample meets a full one.
module fadc_pulse_feature_extractor #(
	parameter int MAX_SAMPLES = 512,
	parameter int BASELINE_SAMPLES = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [9:0]                  sample,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [9:0]                  window_max,
	output logic                        window_hit,
	output logic signed [19:0]          window_integral,
	output logic signed [19:0]          pedestal_integral,
	output logic [12:0]                 baseline_sum,
	output logic [9:0]                  peak_value,
	output logic [8:0]                  peak_index,
	output logic                        clean_pulse,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fpfe_pkg::PADDR_W-1:0] paddr,
	input  logic [fpfe_pkg::PDATA_W-1:0] pwdata,
	output logic [fpfe_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import fpfe_pkg::*;

	cfg_t              cfg_q;
	reg_index_t        reg_sel;
	logic              cfg_wr;

	logic              valid_s1;
	logic [ADC_W-1:0]  sample_s1;
	logic              last_s1;
	logic              out_free;
	logic              step;
	logic              load;

	res_t              res;
	res_t              out_res_q;
	logic              out_valid_q;

	assign pready = 1'b1;
	assign reg_sel = reg_index_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start <= WINDOW_START_RST;
			cfg_q.window_end <= WINDOW_END_RST;
			cfg_q.pedestal_offset <= PEDESTAL_OFFSET_RST;
			cfg_q.peak_thresh <= PEAK_THRESH_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_WINDOW_START: begin
					cfg_q.window_start <= pwdata[INDEX_W-1:0];
				end
				REG_WINDOW_END: begin
					cfg_q.window_end <= pwdata[INDEX_W-1:0];
				end
				REG_PEDESTAL_OFFSET: begin
					cfg_q.pedestal_offset <= pwdata[ADC_W-1:0];
				end
				REG_PEAK_THRESH: begin
					cfg_q.peak_thresh <= pwdata[ADC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WINDOW_START:    prdata = PDATA_W'(cfg_q.window_start);
			REG_WINDOW_END:      prdata = PDATA_W'(cfg_q.window_end);
			REG_PEDESTAL_OFFSET: prdata = PDATA_W'(cfg_q.pedestal_offset);
			REG_PEAK_THRESH:     prdata = PDATA_W'(cfg_q.peak_thresh);
			default:             prdata = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign step = valid_s1 && (!last_s1 || out_free);
	assign load = step && last_s1;
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
			last_s1 <= last;
		end
	end

	fpfe_accum #(
		.MAX_SAMPLES      (MAX_SAMPLES),
		.BASELINE_SAMPLES (BASELINE_SAMPLES)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.last   (last_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign window_max = out_res_q.window_max;
	assign window_hit = out_res_q.window_hit;
	assign window_integral = out_res_q.window_integral;
	assign pedestal_integral = out_res_q.pedestal_integral;
	assign baseline_sum = out_res_q.baseline_sum;
	assign peak_value = out_res_q.peak_value;
	assign peak_index = out_res_q.peak_index;
	assign clean_pulse = out_res_q.clean_pulse;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_last_makes_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("last sample did not produce a result");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !window_hit) |-> (window_max == '0 && window_integral == '0))
		else $error("empty window with nonzero max or integral");

	a_clean_unsaturated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clean_pulse) |-> (peak_value != ADC_FULL))
		else $error("clean pulse reported with a saturated peak");

endmodule
